FILE: sv/bkhm_pkg.sv
// Shared types and constants of the byte key hash mixer.
package bkhm_pkg;

	localparam logic [31:0] HASH_INIT   = 32'hdeadbeef;
	localparam int          BLOCK_BYTES = 12;
	localparam int          QUEUE_DEPTH = 4;

	// What the back end does once a classified byte has been folded in.
	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_MIX,
		KIND_FINAL,
		KIND_ZERO
	} kind_t;

	// Which hash word a byte lands in.
	typedef enum logic [1:0] {
		SEL_A,
		SEL_B,
		SEL_C
	} sel_t;

	// One classified key byte, as it travels through the queue.
	typedef struct packed {
		logic        start;
		logic [31:0] init;
		logic [31:0] add;
		sel_t        sel;
		kind_t       kind;
	} op_t;

	// One finished block handed to the mixing sequencer.
	typedef struct packed {
		logic        start;
		logic [31:0] init;
		logic [31:0] acc_a;
		logic [31:0] acc_b;
		logic [31:0] acc_c;
		kind_t       kind;
	} job_t;

endpackage

FILE: sv/bkhm_if.sv
// Handshake channels of the byte key hash mixer: key bytes in, hash values out.
interface bkhm_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  key_byte;
	logic [31:0] key_length;
	logic [31:0] seed;

	modport source(output valid, output key_byte, output key_length, output seed,
		input ready);
	modport sink(input valid, input key_byte, input key_length, input seed,
		output ready);
endinterface

interface bkhm_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest;

	modport source(output valid, output digest, input ready);
	modport sink(input valid, input digest, output ready);
endinterface

FILE: sv/bkhm_queue.sv
// Small register FIFO between the classifying front end and the back end.
module bkhm_queue #(
	parameter int WIDTH = 1,
	parameter int DEPTH = bkhm_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[head_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) tail_q <= ptr_inc(tail_q);
			if (do_pop) head_q <= ptr_inc(head_q);
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[tail_q] <= push_data;
	end

endmodule

FILE: sv/bkhm_front.sv
// Front end: tracks key position and length, and classifies each key byte.
module bkhm_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	bkhm_in_if.sink          in_ch,
	output logic             op_valid,
	input  logic             op_ready,
	output bkhm_pkg::op_t    op
);

	logic        byte_order_q;
	logic        active_q;
	logic [3:0]  pos_q;
	logic [31:0] left_q;

	logic        start, accept, zero_len, last, block_end;
	logic [3:0]  pos;
	logic [31:0] len, left_next;
	logic [1:0]  lane;
	logic [4:0]  shift;

	assign in_ch.ready = op_ready;
	assign op_valid    = in_ch.valid;
	assign accept      = in_ch.valid && op_ready;

	always_comb begin
		start     = !active_q;
		len       = start ? in_ch.key_length : left_q;
		pos       = start ? 4'd0 : pos_q;
		if (pos > 4'(bkhm_pkg::BLOCK_BYTES - 1)) pos = 4'(bkhm_pkg::BLOCK_BYTES - 1);
		zero_len  = start && (in_ch.key_length == '0);
		left_next = len - 1'b1;
		last      = (left_next == '0);
		block_end = (pos == 4'(bkhm_pkg::BLOCK_BYTES - 1));
		// Big-endian packing mirrors the lane inside the word.
		lane      = byte_order_q ? ~pos[1:0] : pos[1:0];
		shift     = {lane, 3'b000};

		op.start = start;
		op.init  = bkhm_pkg::HASH_INIT + in_ch.key_length + in_ch.seed;
		op.add   = zero_len ? '0 : (32'(in_ch.key_byte) << shift);
		if (pos < 4'd4) op.sel = bkhm_pkg::SEL_A;
		else if (pos < 4'd8) op.sel = bkhm_pkg::SEL_B;
		else op.sel = bkhm_pkg::SEL_C;
		priority if (zero_len) op.kind = bkhm_pkg::KIND_ZERO;
		else if (last) op.kind = bkhm_pkg::KIND_FINAL;
		else if (block_end) op.kind = bkhm_pkg::KIND_MIX;
		else op.kind = bkhm_pkg::KIND_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_order_q <= 1'b0;
			active_q     <= 1'b0;
			pos_q        <= '0;
			left_q       <= '0;
		end else begin
			if (cfg_we) byte_order_q <= cfg_wdata;
			if (accept) begin
				active_q <= !(zero_len || last);
				pos_q    <= (last || block_end || zero_len) ? 4'd0 : pos + 1'b1;
				left_q   <= zero_len ? '0 : left_next;
			end
		end
	end

endmodule

FILE: sv/bkhm_back.sv
// Back end: gathers each block's bytes, then mixes it into the hash words.
module bkhm_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             op_valid,
	output logic             op_ready,
	input  bkhm_pkg::op_t    op,
	bkhm_out_if.source       out_ch
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BMIX = 2'd1;
	localparam logic [1:0] ST_FMIX = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;
	localparam int BMIX_ROWS = 6;
	localparam int FMIX_ROWS = 7;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} words_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] k);
		logic [63:0] t;
		t = {x, x} << k;
		return t[63:32];
	endfunction

	function automatic words_t bmix_row(input words_t w, input logic [2:0] step);
		words_t r;
		r = w;
		unique case (step)
			3'd0: begin r.a = (r.a - r.c) ^ rotl(r.c, 5'd4);  r.c = r.c + r.b; end
			3'd1: begin r.b = (r.b - r.a) ^ rotl(r.a, 5'd6);  r.a = r.a + r.c; end
			3'd2: begin r.c = (r.c - r.b) ^ rotl(r.b, 5'd8);  r.b = r.b + r.a; end
			3'd3: begin r.a = (r.a - r.c) ^ rotl(r.c, 5'd16); r.c = r.c + r.b; end
			3'd4: begin r.b = (r.b - r.a) ^ rotl(r.a, 5'd19); r.a = r.a + r.c; end
			3'd5: begin r.c = (r.c - r.b) ^ rotl(r.b, 5'd4);  r.b = r.b + r.a; end
			default: r = w;
		endcase
		return r;
	endfunction

	function automatic words_t fmix_row(input words_t w, input logic [2:0] step);
		words_t r;
		r = w;
		unique case (step)
			3'd0: r.c = (r.c ^ r.b) - rotl(r.b, 5'd14);
			3'd1: r.a = (r.a ^ r.c) - rotl(r.c, 5'd11);
			3'd2: r.b = (r.b ^ r.a) - rotl(r.a, 5'd25);
			3'd3: r.c = (r.c ^ r.b) - rotl(r.b, 5'd16);
			3'd4: r.a = (r.a ^ r.c) - rotl(r.c, 5'd4);
			3'd5: r.b = (r.b ^ r.a) - rotl(r.a, 5'd14);
			3'd6: r.c = (r.c ^ r.b) - rotl(r.b, 5'd24);
			default: r = w;
		endcase
		return r;
	endfunction

	// Block gatherer.
	logic [31:0]     acc_a_q, acc_b_q, acc_c_q, pend_init_q;
	logic            pend_start_q;
	logic [31:0]     new_a, new_b, new_c;
	logic            handoff, pop;

	// Job register and mixing sequencer.
	bkhm_pkg::job_t  job_q;
	logic            job_vld_q, job_take, job_free;
	logic [1:0]      state_q;
	logic [2:0]      step_q;
	words_t          words_q, base;
	logic            out_vld_q, out_load;
	logic [31:0]     out_data_q;

	assign job_take = job_vld_q && (state_q == ST_IDLE);
	assign job_free = !job_vld_q || job_take;
	assign handoff  = (op.kind != bkhm_pkg::KIND_NONE);
	assign op_ready = !handoff || job_free;
	assign pop      = op_valid && op_ready;

	// The bytes of a block are summed per word, since the byte order may change
	// inside a key; the sums join the hash words when the sequencer takes the job.
	always_comb begin
		new_a = (op.start ? '0 : acc_a_q) + ((op.sel == bkhm_pkg::SEL_A) ? op.add : '0);
		new_b = (op.start ? '0 : acc_b_q) + ((op.sel == bkhm_pkg::SEL_B) ? op.add : '0);
		new_c = (op.start ? '0 : acc_c_q) + ((op.sel == bkhm_pkg::SEL_C) ? op.add : '0);
		base  = job_q.start ? words_t'{a: job_q.init, b: job_q.init, c: job_q.init}
			: words_q;
	end

	assign out_load = (state_q == ST_OUT) && (!out_vld_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_start_q <= 1'b0;
			job_vld_q    <= 1'b0;
			state_q      <= ST_IDLE;
			step_q       <= '0;
			out_vld_q    <= 1'b0;
		end else begin
			if (pop) begin
				if (handoff) pend_start_q <= 1'b0;
				else if (op.start) pend_start_q <= 1'b1;
			end
			if (pop && handoff) job_vld_q <= 1'b1;
			else if (job_take) job_vld_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (job_take) begin
						unique case (job_q.kind)
							bkhm_pkg::KIND_MIX:   state_q <= ST_BMIX;
							bkhm_pkg::KIND_FINAL: state_q <= ST_FMIX;
							bkhm_pkg::KIND_ZERO:  state_q <= ST_OUT;
							default:              state_q <= ST_IDLE;
						endcase
					end
				end
				ST_BMIX: begin
					step_q <= step_q + 1'b1;
					if (step_q == 3'(BMIX_ROWS - 1)) state_q <= ST_IDLE;
				end
				ST_FMIX: begin
					step_q <= step_q + 1'b1;
					if (step_q == 3'(FMIX_ROWS - 1)) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (out_load) out_vld_q <= 1'b1;
			else if (out_ch.ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (handoff) begin
				job_q.start <= op.start || pend_start_q;
				job_q.init  <= op.start ? op.init : pend_init_q;
				job_q.acc_a <= new_a;
				job_q.acc_b <= new_b;
				job_q.acc_c <= new_c;
				job_q.kind  <= op.kind;
				acc_a_q     <= '0;
				acc_b_q     <= '0;
				acc_c_q     <= '0;
			end else begin
				acc_a_q <= new_a;
				acc_b_q <= new_b;
				acc_c_q <= new_c;
				if (op.start) pend_init_q <= op.init;
			end
		end
		if (job_take) begin
			words_q.a <= base.a + job_q.acc_a;
			words_q.b <= base.b + job_q.acc_b;
			words_q.c <= base.c + job_q.acc_c;
		end else if (state_q == ST_BMIX) begin
			words_q <= bmix_row(words_q, step_q);
		end else if (state_q == ST_FMIX) begin
			words_q <= fmix_row(words_q, step_q);
		end
		if (out_load) out_data_q <= words_q.c;
	end

	assign out_ch.valid  = out_vld_q;
	assign out_ch.digest = out_data_q;

endmodule

FILE: sv/byte_key_hash_mixer.sv
// Top level of the byte key hash mixer: front end, op queue and back end.
//
//   channel   direction  payload                        transaction when
//   in_ch     in         key_byte, key_length, seed     valid && ready
//   out_ch    out        digest                         valid && ready
//   cfg       in         cfg_wdata (byte_order)         cfg_we high
//
// Key bytes are taken one per cycle while the op queue has room. Each 12-byte
// block is gathered, then mixed (load, six rows) while the next block is gathered.
// A key end is mixed by load, seven final rows and output; an empty key goes
// straight from load to output.
// A stalled output holds the sequencer; the queue then fills and in_ch.ready falls.
// Reset clears all control state; no clearing pass is needed.
module byte_key_hash_mixer #(
	parameter int QUEUE_DEPTH = bkhm_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	bkhm_in_if.sink     in_ch,
	bkhm_out_if.source  out_ch
);

	localparam int OP_W = $bits(bkhm_pkg::op_t);

	bkhm_pkg::op_t   push_op, pop_op;
	logic            push_valid, push_ready, pop_valid, pop_ready;
	logic [OP_W-1:0] pop_bits;

	bkhm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.op_valid  (push_valid),
		.op_ready  (push_ready),
		.op        (push_op)
	);

	bkhm_queue #(
		.WIDTH (OP_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_op),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_bits)
	);

	assign pop_op = bkhm_pkg::op_t'(pop_bits);

	bkhm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (pop_valid),
		.op_ready (pop_ready),
		.op       (pop_op),
		.out_ch   (out_ch)
	);

endmodule
